// File: src/ccsr_pkg.sv
// Shared types and codes for the character canvas shape rasterizer.
`default_nettype none
package ccsr_pkg;

	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SHP_LINE   = 2'd0,
		SHP_RECT   = 2'd1,
		SHP_TRI    = 2'd2,
		SHP_CIRCLE = 2'd3
	} shape_t;

	localparam logic REG_BACKGROUND = 1'b0;
	localparam logic REG_ASPECT     = 1'b1;

	// One request as it sits in the queue between front and back.
	typedef struct packed {
		action_t    action;
		shape_t     shape_kind;
		logic [5:0] ax;
		logic [4:0] ay;
		logic [5:0] bx;
		logic [4:0] by;
		logic [5:0] cx;
		logic [4:0] cy;
		logic [4:0] radius;
		logic [7:0] ink_char;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LINE_SETUP,
		ST_LINE_RUN,
		ST_RECT_TOP,
		ST_RECT_SIDE,
		ST_CIRC_PLOT,
		ST_CIRC_STEP,
		ST_CLEAR,
		ST_READ,
		ST_READ_OUT,
		ST_CLEAR_INIT
	} bstate_t;

endpackage
`default_nettype wire

// File: src/char_canvas_shape_rasterizer.sv
// Top level: config registers, request front end and rasterizer back end.
//  channel | dir | handshake        | payload
//  in      | in  | in_valid/in_stall   | action..ink_char
//  out     | out | out_valid/out_stall | cell_char
//  cfg     | in  | APB psel/penable    | background_char, aspect_correct
// After reset a clearing pass fills the canvas with 32; no draw runs meanwhile.
// Draw writes one cell per plotted point: 8 per circle step, 2 per rect column/row.
// Clear rewrites all COLS*ROWS cells; a read passes ST_READ and ST_READ_OUT; the canvas write port sets the rate.
// A two-entry queue lets requests arrive while the back end works.
`default_nettype none
module char_canvas_shape_rasterizer #(
	parameter int CANVAS_COLS = 60,
	parameter int CANVAS_ROWS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [1:0]  shape_kind,
	input  wire logic [5:0]  ax,
	input  wire logic [4:0]  ay,
	input  wire logic [5:0]  bx,
	input  wire logic [4:0]  by,
	input  wire logic [5:0]  cx,
	input  wire logic [4:0]  cy,
	input  wire logic [4:0]  radius,
	input  wire logic [7:0]  ink_char,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       cell_char
);
	import ccsr_pkg::*;

	logic [7:0] background_q;
	logic       aspect_q;
	cmd_t       in_cmd, q_cmd;
	logic       q_valid, q_take;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q <= 8'd32;
			aspect_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_BACKGROUND) background_q <= pwdata[7:0];
			else aspect_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_ASPECT) ? {31'd0, aspect_q} : {24'd0, background_q};

	always_comb begin
		in_cmd.action = action_t'(action);
		in_cmd.shape_kind = shape_t'(shape_kind);
		in_cmd.ax = ax; in_cmd.ay = ay;
		in_cmd.bx = bx; in_cmd.by = by;
		in_cmd.cx = cx; in_cmd.cy = cy;
		in_cmd.radius = radius;
		in_cmd.ink_char = ink_char;
	end

	ccsr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take)
	);

	ccsr_back #(.COLS(CANVAS_COLS), .ROWS(CANVAS_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_take(q_take),
		.background_char(background_q), .aspect_correct(aspect_q),
		.out_valid(out_valid), .out_stall(out_stall), .cell_char(cell_char)
	);
endmodule
`default_nettype wire

// File: src/ccsr_front.sv
// Front end: accepts requests, drops unused action codes, holds a two-entry queue.
`default_nettype none
module ccsr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire ccsr_pkg::cmd_t in_cmd,
	output logic                q_valid,
	output ccsr_pkg::cmd_t      q_cmd,
	input  wire logic           q_take
);
	import ccsr_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall && (in_cmd.action != ACT_NONE);
	assign pop = q_take && q_valid;
	assign q_valid = (count_q != 2'd0);
	assign q_cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1) else $error("count slip");
`endif
endmodule
`default_nettype wire

// File: src/ccsr_back.sv
// Back end: rasterizer and canvas memory, at most one cell write per cycle.
`default_nettype none
module ccsr_back #(
	parameter int COLS = 60,
	parameter int ROWS = 20
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire ccsr_pkg::cmd_t q_cmd,
	output logic                q_take,
	input  wire logic [7:0]     background_char,
	input  wire logic           aspect_correct,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          cell_char
);
	import ccsr_pkg::*;

	localparam int DEPTH = COLS * ROWS;
	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	bstate_t    state_q, state_d;
	cmd_t       cmd_q;
	// signed walk coordinates, wide enough for circle offsets (+/-2*31+63)
	logic signed [8:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [8:0] dx_q, dy_q;
	logic signed [10:0] err_q;
	logic sx_q, sy_q;
	logic [1:0] seg_q;
	logic signed [8:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, i_q;
	logic side_q;
	logic signed [6:0] cxo_q, cyo_q;
	logic signed [11:0] d_q;
	logic [2:0] oct_q;
	logic [AW:0] clr_q;
	logic [7:0] clr_val_q;
	logic [7:0] rd_q;
	logic rd_ok_q;
	logic [7:0] cell_q;
	logic out_valid_q;

	// write port
	logic              we;
	logic signed [8:0] px, py;
	logic [7:0]        wdata;
	logic              wclear;
	logic [AW-1:0]     waddr;
	logic              in_bounds;

	function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] y);
		logic [AW+8:0] a;
		a = (AW+9)'(y) * (AW+9)'(COLS) + (AW+9)'(x);
		return a[AW-1:0];
	endfunction

	// next line step
	logic signed [11:0] e2;
	logic stepx, stepy, line_end;
	assign e2 = {err_q[10], err_q} <<< 1;
	assign stepx = e2 >= 12'(dy_q);
	assign stepy = e2 <= 12'(dx_q);
	assign line_end = (x0_q == x1_q) && (y0_q == y1_q);

	// circle octant point
	logic signed [8:0] ox, oy, xs, ys;
	always_comb begin
		xs = aspect_correct ? 9'(cxo_q) <<< 1 : 9'(cxo_q);
		ys = aspect_correct ? 9'(cyo_q) <<< 1 : 9'(cyo_q);
		case (oct_q)
			3'd0: begin ox = xs;  oy = 9'(cyo_q);  end
			3'd1: begin ox = -xs; oy = 9'(cyo_q);  end
			3'd2: begin ox = xs;  oy = -9'(cyo_q); end
			3'd3: begin ox = -xs; oy = -9'(cyo_q); end
			3'd4: begin ox = ys;  oy = 9'(cxo_q);  end
			3'd5: begin ox = -ys; oy = 9'(cxo_q);  end
			3'd6: begin ox = ys;  oy = -9'(cxo_q); end
			default: begin ox = -ys; oy = -9'(cxo_q); end
		endcase
	end

	// triangle segment endpoints
	logic signed [8:0] sa_x, sa_y, sb_x, sb_y;
	always_comb begin
		case (seg_q)
			2'd0: begin
				sa_x = 9'(cmd_q.ax); sa_y = 9'(cmd_q.ay);
				sb_x = 9'(cmd_q.bx); sb_y = 9'(cmd_q.by);
			end
			2'd1: begin
				sa_x = 9'(cmd_q.bx); sa_y = 9'(cmd_q.by);
				sb_x = 9'(cmd_q.cx); sb_y = 9'(cmd_q.cy);
			end
			default: begin
				sa_x = 9'(cmd_q.cx); sa_y = 9'(cmd_q.cy);
				sb_x = 9'(cmd_q.ax); sb_y = 9'(cmd_q.ay);
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		q_take = 1'b0;
		we = 1'b0;
		wclear = 1'b0;
		px = x0_q;
		py = y0_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_take = 1'b1;
					case (q_cmd.action)
						ACT_DRAW: begin
							case (q_cmd.shape_kind)
								SHP_RECT: state_d = ST_RECT_TOP;
								SHP_CIRCLE: state_d = ST_CIRC_PLOT;
								default: state_d = ST_LINE_SETUP;
							endcase
						end
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_READ: state_d = ST_READ;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LINE_SETUP: state_d = ST_LINE_RUN;
			ST_LINE_RUN: begin
				we = 1'b1;
				if (line_end) begin
					if (cmd_q.shape_kind == SHP_TRI && seg_q != 2'd2) state_d = ST_LINE_SETUP;
					else state_d = ST_IDLE;
				end
			end
			ST_RECT_TOP: begin
				we = 1'b1;
				px = i_q;
				py = side_q ? hi_y_q : lo_y_q;
				if (side_q && i_q == hi_x_q) state_d = ST_RECT_SIDE;
			end
			ST_RECT_SIDE: begin
				we = 1'b1;
				px = side_q ? hi_x_q : lo_x_q;
				py = i_q;
				if (side_q && i_q == hi_y_q) state_d = ST_IDLE;
			end
			ST_CIRC_PLOT: begin
				we = 1'b1;
				px = 9'(cmd_q.ax) + ox;
				py = 9'(cmd_q.ay) + oy;
				if (oct_q == 3'd7) state_d = (cyo_q >= cxo_q) ? ST_CIRC_STEP : ST_IDLE;
			end
			ST_CIRC_STEP: state_d = ST_CIRC_PLOT;
			ST_CLEAR, ST_CLEAR_INIT: begin
				wclear = 1'b1;
				if (clr_q == (AW+1)'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_READ: state_d = ST_READ_OUT;
			ST_READ_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_bounds = (px >= 0) && (px < 9'(COLS)) && (py >= 0) && (py < 9'(ROWS));
	assign waddr = wclear ? clr_q[AW-1:0] : addr_of(px, py);
	assign wdata = wclear ? clr_val_q : cmd_q.ink_char;

	always_ff @(posedge clk) begin
		if (wclear || (we && in_bounds)) mem[waddr] <= wdata;
		rd_q <= mem[addr_of(9'(cmd_q.ax), 9'(cmd_q.ay))];
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			cmd_q <= q_cmd;
			seg_q <= 2'd0;
			side_q <= 1'b0;
			oct_q <= 3'd0;
			cxo_q <= 7'sd0;
			cyo_q <= 7'(q_cmd.radius);
			d_q <= 12'sd3 - (12'(q_cmd.radius) <<< 1);
			if (q_cmd.ax < q_cmd.bx) begin
				lo_x_q <= 9'(q_cmd.ax); hi_x_q <= 9'(q_cmd.bx); i_q <= 9'(q_cmd.ax);
			end else begin
				lo_x_q <= 9'(q_cmd.bx); hi_x_q <= 9'(q_cmd.ax); i_q <= 9'(q_cmd.bx);
			end
			if (q_cmd.ay < q_cmd.by) begin
				lo_y_q <= 9'(q_cmd.ay); hi_y_q <= 9'(q_cmd.by);
			end else begin
				lo_y_q <= 9'(q_cmd.by); hi_y_q <= 9'(q_cmd.ay);
			end
		end
		case (state_q)
			ST_LINE_SETUP: begin
				x0_q <= sa_x; y0_q <= sa_y; x1_q <= sb_x; y1_q <= sb_y;
				dx_q <= (sb_x > sa_x) ? sb_x - sa_x : sa_x - sb_x;
				dy_q <= (sb_y > sa_y) ? sa_y - sb_y : sb_y - sa_y;
				err_q <= 11'((sb_x > sa_x) ? sb_x - sa_x : sa_x - sb_x)
					+ 11'((sb_y > sa_y) ? sa_y - sb_y : sb_y - sa_y);
				sx_q <= sa_x < sb_x;
				sy_q <= sa_y < sb_y;
			end
			ST_LINE_RUN: begin
				if (!line_end) begin
					err_q <= err_q + (stepx ? 11'(dy_q) : 11'sd0) + (stepy ? 11'(dx_q) : 11'sd0);
					if (stepx) x0_q <= sx_q ? x0_q + 9'sd1 : x0_q - 9'sd1;
					if (stepy) y0_q <= sy_q ? y0_q + 9'sd1 : y0_q - 9'sd1;
				end else seg_q <= seg_q + 2'd1;
			end
			ST_RECT_TOP: begin
				// each column: top then bottom
				side_q <= ~side_q;
				if (side_q) i_q <= (i_q == hi_x_q) ? lo_y_q : i_q + 9'sd1;
			end
			ST_RECT_SIDE: begin
				side_q <= ~side_q;
				if (side_q) i_q <= i_q + 9'sd1;
			end
			ST_CIRC_PLOT: oct_q <= oct_q + 3'd1;
			ST_CIRC_STEP: begin
				cxo_q <= cxo_q + 7'sd1;
				if (d_q > 0) begin
					cyo_q <= cyo_q - 7'sd1;
					d_q <= d_q + ((12'(cxo_q) + 12'sd1 - 12'(cyo_q) + 12'sd1) <<< 2) + 12'sd10;
				end else begin
					d_q <= d_q + ((12'(cxo_q) + 12'sd1) <<< 2) + 12'sd6;
				end
			end
			ST_READ: rd_ok_q <= (7'(cmd_q.ax) < 7'(COLS)) && (6'(cmd_q.ay) < 6'(ROWS));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR_INIT;
			clr_q <= '0;
			clr_val_q <= 8'd32;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wclear) clr_q <= (clr_q == (AW+1)'(DEPTH - 1)) ? '0 : clr_q + 1'b1;
			if (q_take) clr_val_q <= background_char;
			if (state_q == ST_READ_OUT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ_OUT) cell_q <= rd_ok_q ? rd_q : 8'd0;
	end

	assign out_valid = out_valid_q;
	assign cell_char = cell_q;

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> state_q == ST_IDLE) else $error("take outside idle");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ_OUT |=> out_valid) else $error("read result lost");
	a_clear_no_draw: assert property (@(posedge clk) disable iff (!arst_n)
		wclear |-> !we) else $error("clear and draw overlap");
`endif
endmodule
`default_nettype wire
